[design/sspr_pkg.sv]
// Shared constants, register codes and the arctangent table of the phase rotator.
// Used by every module of the rotator; depends on nothing.
package sspr_pkg;

	localparam int GUARD        = 12;
	localparam int CORDIC_STEPS = 30;
	localparam int POT_W        = 24;
	localparam int PSCALE_W     = 24;
	localparam int KCOEFF_W     = 32;
	localparam int TURN_W       = 32;
	localparam int DATA_W       = 32;
	localparam int INDEX_W      = 3;
	localparam logic [29:0] INVK_Q30 = 30'd652032874;

	typedef enum logic [INDEX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_PSCALE  = 3'd1,
		REG_KCOEFF  = 3'd2,
		REG_COLUMNS = 3'd3,
		REG_ROWS    = 3'd4
	} reg_index_t;

	function automatic logic [TURN_W-1:0] atan_turn(input int step);
		logic [TURN_W-1:0] a;
		case (step)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[design/sspr_phase.sv]
// Three-stage front end: phase angle from potential or frequency, quarter-turn fold.
// Depends on sspr_pkg.
module sspr_phase #(
	parameter int AW = 18,
	parameter int PW = 24,
	parameter int IW = 10,
	parameter int SW = 11,
	parameter int XW = 33
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [AW-1:0]                 re_in,
	input  logic signed [AW-1:0]                 im_in,
	input  logic signed [sspr_pkg::POT_W-1:0]    potential,
	input  logic [IW-1:0]                        col,
	input  logic [IW-1:0]                        row,
	input  logic                                 mode,
	input  logic [sspr_pkg::PSCALE_W-1:0]        pscale,
	input  logic [sspr_pkg::KCOEFF_W-1:0]        kcoeff,
	input  logic [SW-1:0]                        columns,
	input  logic [SW-1:0]                        rows,
	output logic                                 out_valid,
	output logic signed [XW-1:0]                 x_out,
	output logic signed [XW-1:0]                 y_out,
	output logic signed [sspr_pkg::TURN_W-1:0]   z_out
);

	localparam int PPW = sspr_pkg::PSCALE_W + sspr_pkg::POT_W + 1;
	localparam int SQW = 2 * SW + 1;
	localparam int KPW = sspr_pkg::KCOEFF_W + SQW;

	logic signed [PPW-1:0] pprod;
	logic signed [SW:0]    fx, fy;
	logic [KPW-1:0]        kprod;
	logic [PW-1:0]         phase;
	logic [31:0]           zt;
	logic                  fold;
	logic signed [AW:0]    xn, yn;

	logic                  valid_s1, valid_s2;
	logic signed [AW-1:0]  x_s1, y_s1, x_s2, y_s2;
	logic                  mode_s1, mode_s2;
	logic [PW-1:0]         pphase_s1, pphase_s2;
	logic signed [SW:0]    fx_s1, fy_s1;
	logic [SQW-1:0]        sq_s2;

	always_comb begin
		pprod = $signed({1'b0, pscale}) * PPW'(potential);
		if ({1'b0, col} > ((SW+1)'(columns) >> 1))
			fx = $signed((SW+1)'(col)) - $signed({1'b0, columns});
		else
			fx = $signed((SW+1)'(col));
		if ({1'b0, row} > ((SW+1)'(rows) >> 1))
			fy = $signed((SW+1)'(row)) - $signed({1'b0, rows});
		else
			fy = $signed((SW+1)'(row));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1      <= re_in;
		y_s1      <= im_in;
		mode_s1   <= mode;
		pphase_s1 <= pprod[40-PW +: PW];
		fx_s1     <= fx;
		fy_s1     <= fy;
		x_s2      <= x_s1;
		y_s2      <= y_s1;
		mode_s2   <= mode_s1;
		pphase_s2 <= pphase_s1;
		sq_s2     <= SQW'(fx_s1 * fx_s1) + SQW'(fy_s1 * fy_s1);
	end

	always_comb begin
		kprod = KPW'(kcoeff) * KPW'(sq_s2);
		phase = mode_s2 ? kprod[32-PW +: PW] : pphase_s2;
		zt    = 32'(phase) << (32 - PW);
		fold  = (zt[31:30] == 2'b01) || (zt[31:30] == 2'b10);
		xn    = (AW+1)'(x_s2);
		yn    = (AW+1)'(y_s2);
		if (fold) begin
			xn = -xn;
			yn = -yn;
			zt[31] = ~zt[31];
		end
	end

	always_ff @(posedge clk) begin
		x_out <= XW'(xn) <<< sspr_pkg::GUARD;
		y_out <= XW'(yn) <<< sspr_pkg::GUARD;
		z_out <= $signed(zt);
	end

endmodule

[design/sspr_cell.sv]
// One registered CORDIC rotation step with its fixed shift and arctangent.
// Depends on sspr_pkg.
module sspr_cell #(
	parameter int STEP = 0,
	parameter int XW   = 33
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [XW-1:0]               x_in,
	input  logic signed [XW-1:0]               y_in,
	input  logic signed [sspr_pkg::TURN_W-1:0] z_in,
	output logic                               out_valid,
	output logic signed [XW-1:0]               x_out,
	output logic signed [XW-1:0]               y_out,
	output logic signed [sspr_pkg::TURN_W-1:0] z_out
);

	localparam logic signed [sspr_pkg::TURN_W-1:0] ANGLE = sspr_pkg::atan_turn(STEP);

	logic signed [XW-1:0] dx, dy;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!z_in[sspr_pkg::TURN_W-1]) begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - ANGLE;
		end else begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + ANGLE;
		end
	end

endmodule

[design/sspr_gain.sv]
// Two-stage gain correction: multiply by the inverse CORDIC gain, round, saturate.
// Depends on sspr_pkg.
module sspr_gain #(
	parameter int AW = 18,
	parameter int XW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	output logic                 out_valid,
	output logic signed [AW-1:0] x_out,
	output logic signed [AW-1:0] y_out
);

	localparam int FRAC_RAW = 62 - AW - sspr_pkg::GUARD;
	localparam int FRAC     = (FRAC_RAW > 30) ? 30 : FRAC_RAW;
	localparam int SH       = sspr_pkg::GUARD + FRAC;
	localparam int PRW      = XW + 31;
	localparam logic [29:0] INVK = sspr_pkg::INVK_Q30 >> (30 - FRAC);
	localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (SH - 1);
	localparam logic signed [PRW-1:0] HI   = PRW'((64'sd1 <<< (AW - 1)) - 1);
	localparam logic signed [PRW-1:0] LO   = -HI - PRW'(1);

	logic                  valid_s1;
	logic signed [PRW-1:0] px_s1, py_s1;
	logic signed [PRW-1:0] rx, ry;

	function automatic logic signed [AW-1:0] clip(input logic signed [PRW-1:0] v);
		logic signed [PRW-1:0] c;
		c = v;
		if (v > HI)
			c = HI;
		else if (v < LO)
			c = LO;
		return c[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_comb begin
		rx = (px_s1 + HALF) >>> SH;
		ry = (py_s1 + HALF) >>> SH;
	end

	always_ff @(posedge clk) begin
		px_s1 <= PRW'(x_in) * $signed({1'b0, INVK});
		py_s1 <= PRW'(y_in) * $signed({1'b0, INVK});
		x_out <= clip(rx);
		y_out <= clip(ry);
	end

endmodule

[design/split_step_phase_rotator_unit.sv]
// Split-step phase rotator: rotates each complex sample by a potential or kinetic phase.
// From start to done an item passes three phase stages, thirty CORDIC cells and two gain stages.
// Throughput is one item per cycle; busy is always low and the result cannot be stalled.
// Reset clears the configuration to its defaults and empties the pipeline at once.
// Depends on sspr_pkg, sspr_phase, sspr_cell and sspr_gain.
module split_step_phase_rotator_unit #(
	parameter int MAX_DIM     = 1024,
	parameter int AMP_WIDTH   = 18,
	parameter int PHASE_WIDTH = 24,
	localparam int IW = $clog2(MAX_DIM),
	localparam int SW = $clog2(MAX_DIM + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [AMP_WIDTH-1:0]            re_in,
	input  logic signed [AMP_WIDTH-1:0]            im_in,
	input  logic signed [sspr_pkg::POT_W-1:0]      potential,
	input  logic [IW-1:0]                          col,
	input  logic [IW-1:0]                          row,
	output logic                                   done,
	output logic signed [AMP_WIDTH-1:0]            re_out,
	output logic signed [AMP_WIDTH-1:0]            im_out,
	input  logic                                   wr_en,
	input  logic [sspr_pkg::INDEX_W-1:0]           wr_index,
	input  logic [sspr_pkg::DATA_W-1:0]            wr_data
);

	localparam int XW    = AMP_WIDTH + sspr_pkg::GUARD + 3;
	localparam int NCELL = sspr_pkg::CORDIC_STEPS;
	localparam int LAT   = NCELL + 5;

	logic                              mode_q;
	logic [sspr_pkg::PSCALE_W-1:0]     pscale_q;
	logic [sspr_pkg::KCOEFF_W-1:0]     kcoeff_q;
	logic [SW-1:0]                     columns_q, rows_q;
	logic [SW-1:0]                     size_wr;

	logic                              cv [NCELL+1];
	logic signed [XW-1:0]              cx [NCELL+1];
	logic signed [XW-1:0]              cy [NCELL+1];
	logic signed [sspr_pkg::TURN_W-1:0] cz [NCELL+1];

	assign busy = 1'b0;

	always_comb begin
		size_wr = wr_data[SW-1:0];
		if (size_wr > SW'(MAX_DIM))
			size_wr = SW'(MAX_DIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			pscale_q  <= '0;
			kcoeff_q  <= '0;
			columns_q <= SW'(256);
			rows_q    <= SW'(256);
		end else if (wr_en) begin
			case (wr_index)
				sspr_pkg::REG_MODE:    mode_q    <= wr_data[0];
				sspr_pkg::REG_PSCALE:  pscale_q  <= wr_data[sspr_pkg::PSCALE_W-1:0];
				sspr_pkg::REG_KCOEFF:  kcoeff_q  <= wr_data[sspr_pkg::KCOEFF_W-1:0];
				sspr_pkg::REG_COLUMNS: columns_q <= size_wr;
				sspr_pkg::REG_ROWS:    rows_q    <= size_wr;
				default: ;
			endcase
		end
	end

	sspr_phase #(
		.AW(AMP_WIDTH), .PW(PHASE_WIDTH), .IW(IW), .SW(SW), .XW(XW)
	) u_phase (
		.clk(clk), .arst_n(arst_n),
		.in_valid(start && !busy),
		.re_in(re_in), .im_in(im_in), .potential(potential), .col(col), .row(row),
		.mode(mode_q), .pscale(pscale_q), .kcoeff(kcoeff_q),
		.columns(columns_q), .rows(rows_q),
		.out_valid(cv[0]), .x_out(cx[0]), .y_out(cy[0]), .z_out(cz[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		sspr_cell #(.STEP(i), .XW(XW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
			.out_valid(cv[i+1]), .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
		);
	end

	sspr_gain #(.AW(AMP_WIDTH), .XW(XW)) u_gain (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cv[NCELL]), .x_in(cx[NCELL]), .y_in(cy[NCELL]),
		.out_valid(done), .x_out(re_out), .y_out(im_out)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("An accepted item did not complete after the pipeline latency.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("A result appeared without a matching accepted item.");

	a_zero_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(start && re_in == '0 && im_in == '0) |-> ##LAT (re_out == '0 && im_out == '0))
		else $error("A zero sample did not rotate to zero.");

endmodule

[tb/tb_split_step_phase_rotator_unit.sv]
// Self-checking testbench of split_step_phase_rotator_unit in both phase modes.
// A clocked driver and monitor compare each result with a built-in CORDIC predictor.
// Depends on sspr_pkg and the rotator RTL.
module tb_split_step_phase_rotator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = 18;
	localparam int PW = 24;
	localparam int LIMIT = 200000;
	localparam logic [31:0] ATAN [0:29] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

	typedef struct packed {
		logic signed [AW-1:0] re;
		logic signed [AW-1:0] im;
		logic signed [23:0]   pot;
		logic [9:0]           col;
		logic [9:0]           row;
	} sample_t;

	typedef struct packed {
		logic signed [AW-1:0] re;
		logic signed [AW-1:0] im;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [AW-1:0] re_in = '0;
	logic signed [AW-1:0] im_in = '0;
	logic signed [23:0] potential = '0;
	logic [9:0] col = '0;
	logic [9:0] row = '0;
	logic done;
	logic signed [AW-1:0] re_out;
	logic signed [AW-1:0] im_out;
	logic wr_en = 1'b0;
	logic [sspr_pkg::INDEX_W-1:0] wr_index = '0;
	logic [sspr_pkg::DATA_W-1:0] wr_data = '0;

	sample_t pending[$];
	rotated_t expected_rot[$];
	logic kinetic_mode = 1'b0;
	logic [23:0] pot_scale = '0;
	logic [31:0] kin_coeff = '0;
	int unsigned grid_cols = 256;
	int unsigned grid_rows = 256;
	bit bursty = 1'b1;
	int gap_left = 0;
	int errors = 0;
	int checked = 0;
	int cycles = 0;

	split_step_phase_rotator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.re_in(re_in), .im_in(im_in), .potential(potential), .col(col), .row(row),
		.done(done), .re_out(re_out), .im_out(im_out),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	function automatic longint wrap_index(int unsigned idx, int unsigned size);
		if (idx > size / 2) begin
			return longint'(idx) - longint'(size);
		end
		return longint'(idx);
	endfunction

	function automatic logic signed [AW-1:0] clamp_amp(longint v);
		if (v > 131071) begin
			return 18'sd131071;
		end
		if (v < -131072) begin
			return -18'sd131072;
		end
		return v[AW-1:0];
	endfunction

	function automatic rotated_t rotate_sample(sample_t s);
		longint x, y, zs, fx, fy, sq, dx, dy, prod;
		logic [63:0] bits;
		logic [PW-1:0] ph;
		logic [31:0] z;
		rotated_t r;
		x = s.re;
		y = s.im;
		if (!kinetic_mode) begin
			prod = longint'(pot_scale) * longint'(s.pot);
			bits = prod;
			ph = bits[39:16];
		end else begin
			fx = wrap_index(s.col, grid_cols);
			fy = wrap_index(s.row, grid_rows);
			sq = fx * fx + fy * fy;
			bits = longint'(kin_coeff) * sq;
			ph = bits[31:8];
		end
		z = {ph, 8'h00};
		if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
			x = -x;
			y = -y;
			z = z + 32'h80000000;
		end
		zs = longint'($signed(z));
		x = x <<< sspr_pkg::GUARD;
		y = y <<< sspr_pkg::GUARD;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (zs >= 0) begin
				x = x - dx;
				y = y + dy;
				zs = zs - longint'(ATAN[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				zs = zs + longint'(ATAN[i]);
			end
		end
		r.re = clamp_amp((x * longint'(sspr_pkg::INVK_Q30) + (64'sd1 <<< 41)) >>> 42);
		r.im = clamp_amp((y * longint'(sspr_pkg::INVK_Q30) + (64'sd1 <<< 41)) >>> 42);
		return r;
	endfunction

	always @(posedge clk) begin
		sample_t nxt;
		if (start && !busy) begin
			nxt.re = re_in;
			nxt.im = im_in;
			nxt.pot = potential;
			nxt.col = col;
			nxt.row = row;
			expected_rot.push_back(rotate_sample(nxt));
		end
		if (!(start && busy)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending.size() > 0 && bursty && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 11);
				start <= 1'b0;
			end else if (pending.size() > 0) begin
				nxt = pending.pop_front();
				start <= 1'b1;
				re_in <= nxt.re;
				im_in <= nxt.im;
				potential <= nxt.pot;
				col <= nxt.col;
				row <= nxt.row;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rotated_t want;
		if (arst_n && done) begin
			if (expected_rot.size() == 0) begin
				$display("%0t: result with none expected: re %0d im %0d", $time, re_out, im_out);
				errors++;
			end else begin
				want = expected_rot.pop_front();
				checked++;
				if (re_out !== want.re) begin
					$display("%0t: re_out expected %0d actual %0d", $time, want.re, re_out);
					errors++;
				end
				if (im_out !== want.im) begin
					$display("%0t: im_out expected %0d actual %0d", $time, want.im, im_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input sspr_pkg::reg_index_t idx, input logic [31:0] d);
		logic [10:0] sz;
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		sz = d[10:0];
		if (sz > 11'd1024) begin
			sz = 11'd1024;
		end
		case (idx)
			sspr_pkg::REG_MODE:    kinetic_mode = d[0];
			sspr_pkg::REG_PSCALE:  pot_scale = d[23:0];
			sspr_pkg::REG_KCOEFF:  kin_coeff = d;
			sspr_pkg::REG_COLUMNS: grid_cols = 32'(sz);
			sspr_pkg::REG_ROWS:    grid_rows = 32'(sz);
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (pending.size() > 0 || start || expected_rot.size() > 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic push_item(input int re, input int im, input int pot, input int c, input int r);
		sample_t s;
		s.re = AW'(re);
		s.im = AW'(im);
		s.pot = 24'(pot);
		s.col = 10'(c);
		s.row = 10'(r);
		pending.push_back(s);
	endtask

	task automatic push_random();
		int re, im;
		case ($urandom_range(0, 3))
			0: begin
				re = $urandom_range(0, 1) ? 131071 : -131072;
				im = $urandom_range(0, 1) ? 131071 : -131072;
			end
			default: begin
				re = int'($urandom_range(0, 262143)) - 131072;
				im = int'($urandom_range(0, 262143)) - 131072;
			end
		endcase
		push_item(re, im, int'($urandom_range(0, 16777215)) - 8388608,
			$urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 1024;
			4: return $urandom_range(1025, 2047);
			default: return $urandom_range(2, 1024);
		endcase
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_item(131071, 131071, 0, 0, 0);
		push_item(-131072, -131072, 8388607, 1023, 1023);
		push_item(131071, -131072, -8388608, 0, 0);
		push_item(0, 0, 0, 0, 0);
		drain();

		write_reg(sspr_pkg::REG_MODE, 32'd0);
		write_reg(sspr_pkg::REG_PSCALE, 32'hFFFFFF);
		write_reg(sspr_pkg::REG_KCOEFF, 32'hFFFFFFFF);
		write_reg(sspr_pkg::REG_COLUMNS, 32'd2047);
		write_reg(sspr_pkg::REG_ROWS, 32'd1);
		push_item(131071, 131071, 8388607, 0, 0);
		push_item(-131072, 131071, -8388608, 0, 0);
		push_item(131071, 0, 1, 0, 0);
		push_item(131071, 131071, -1, 0, 0);
		push_item(-131072, -131072, 65536, 0, 0);
		push_item(100000, -90000, 12345, 0, 0);
		drain();

		write_reg(sspr_pkg::REG_MODE, 32'd1);
		push_item(131071, 131071, 0, 0, 0);
		push_item(131071, -131072, 0, 1023, 1023);
		push_item(-131072, 131071, 0, 512, 1);
		push_item(131071, 131071, 0, 513, 0);
		drain();
		write_reg(sspr_pkg::REG_COLUMNS, 32'd0);
		write_reg(sspr_pkg::REG_ROWS, 32'd5);
		write_reg(sspr_pkg::REG_KCOEFF, 32'h01000000);
		push_item(131071, 0, 0, 1023, 7);
		push_item(0, 131071, 0, 3, 2);
		push_item(-131072, -131072, 0, 2, 3);
		push_item(131071, 131071, 0, 1, 1023);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			bursty = (phase < 8) && ($urandom_range(0, 3) != 0);
			write_reg(sspr_pkg::REG_MODE, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: write_reg(sspr_pkg::REG_PSCALE, 32'hFFFFFF);
				1: write_reg(sspr_pkg::REG_PSCALE, 32'd0);
				default: write_reg(sspr_pkg::REG_PSCALE, $urandom_range(0, 24'hFFFFFF));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(sspr_pkg::REG_KCOEFF, 32'hFFFFFFFF);
				1: write_reg(sspr_pkg::REG_KCOEFF, 32'd0);
				default: write_reg(sspr_pkg::REG_KCOEFF, $urandom());
			endcase
			write_reg(sspr_pkg::REG_COLUMNS, pick_size());
			write_reg(sspr_pkg::REG_ROWS, pick_size());
			if ($urandom_range(0, 3) == 0) begin
				write_reg(sspr_pkg::reg_index_t'($urandom_range(5, 7)), $urandom());
			end
			for (int k = 0; k < 50; k++) begin
				push_random();
			end
			drain();
		end

		$display("Checked %0d rotated samples across potential and kinetic phases,", checked);
		$display("with extreme amplitudes, scales, coefficients and grid sizes.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[filelist.f]
design/sspr_pkg.sv
design/sspr_phase.sv
design/sspr_cell.sv
design/sspr_gain.sv
design/split_step_phase_rotator_unit.sv
tb/tb_split_step_phase_rotator_unit.sv
